@@ src/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes and types of the banker's safety allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int PROCESSES  = 8;
    localparam int RESOURCES  = 4;
    localparam int COUNT_BITS = 8;

    localparam int OPC_W      = 2;
    localparam int PIDX_W     = 3;
    localparam int CNT_PORT_W = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [OPC_W-1:0] OP_SET_MAX = 2'd0;
    localparam logic [OPC_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OPC_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OPC_W-1:0] OP_NONE    = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NEED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_AVAIL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNSAFE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CHK  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

@@ src/bsa_ifs.sv @@
// ----------------------------------------------------------------------------
// bsa_ifs
// Command and response channels of the banker's safety allocator.
// ----------------------------------------------------------------------------
interface bsa_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [bsa_pkg::OPC_W-1:0]      opcode;
    logic [bsa_pkg::PIDX_W-1:0]     process_index;
    logic [bsa_pkg::CNT_PORT_W-1:0] count_0;
    logic [bsa_pkg::CNT_PORT_W-1:0] count_1;
    logic [bsa_pkg::CNT_PORT_W-1:0] count_2;
    logic [bsa_pkg::CNT_PORT_W-1:0] count_3;

    modport source (output valid, opcode, process_index, count_0, count_1, count_2,
                    count_3, input ready);
    modport sink (input valid, opcode, process_index, count_0, count_1, count_2,
                  count_3, output ready);
endinterface

interface bsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         granted;
    logic [bsa_pkg::STATUS_W-1:0] status;

    modport source (output valid, granted, status, input ready);
    modport sink (input valid, granted, status, output ready);
endinterface

@@ src/bsa_row_mem.sv @@
// ----------------------------------------------------------------------------
// bsa_row_mem
// Per-process row store (max claim and held counts), registered read.
// Rows never written read as zero.
// ----------------------------------------------------------------------------
module bsa_row_mem #(
    parameter int DEPTH = bsa_pkg::PROCESSES,
    parameter int ROW_W = 2 * bsa_pkg::RESOURCES * bsa_pkg::COUNT_BITS,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [ROW_W-1:0] wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [ROW_W-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we && (32'(waddr) < 32'(DEPTH)))
        begin
            mem[waddr] <= wdata;
        end
        if (re && (32'(raddr) < 32'(DEPTH)))
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we && (32'(waddr) < 32'(DEPTH)))
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= (32'(raddr) < 32'(DEPTH)) ? valid_reg[raddr] : 1'b0;
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ src/bankers_safety_allocator.sv @@
// ----------------------------------------------------------------------------
// bankers_safety_allocator
// Banker's algorithm allocator: max claim / request / release with safety scan.
//
//   channel | dir | contents
//   cmd     | in  | opcode, process_index, count_0..count_3
//   rsp     | out | granted, status
//   cfg     | in  | cfg_wr_en, cfg_index, cfg_data (total_res_0..3)
//
// One transaction at a time. Set max, release, no-op and refused requests finish
// in the check state; a request that reaches the safety scan also runs the scan
// and the finish state, evaluating k rows, one row per cycle out of the row
// memory, at most PROCESSES * PROCESSES. Reset clears the tables through
// per-row valid bits, no clearing pass. A held response stalls the sequencer.
// ----------------------------------------------------------------------------
module bankers_safety_allocator #(
    parameter int PROCESSES  = bsa_pkg::PROCESSES,
    parameter int RESOURCES  = bsa_pkg::RESOURCES,
    parameter int COUNT_BITS = bsa_pkg::COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bsa_cmd_if.sink                        cmd,
    bsa_rsp_if.source                      rsp,
    input  logic                           cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CB    = COUNT_BITS;
    localparam int WK_W  = COUNT_BITS + 1;
    localparam int IDX_W = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int NM_W  = $clog2(PROCESSES + 1);
    localparam int ROW_W = 2 * RESOURCES * COUNT_BITS;

    bsa_pkg::state_t state_reg, state_next;

    logic [CB-1:0]   total_reg  [RESOURCES];
    logic [CB-1:0]   in_use_reg [RESOURCES];
    logic [CB-1:0]   in_use_next[RESOURCES];
    logic [WK_W-1:0] work_reg   [RESOURCES];
    logic [WK_W-1:0] work_next  [RESOURCES];
    logic [CB-1:0]   req_reg    [RESOURCES];
    logic [CB-1:0]   cnt_in     [RESOURCES];

    logic [bsa_pkg::OPC_W-1:0] op_reg;
    logic [IDX_W-1:0]          pidx_reg;
    logic                      in_range_reg;
    logic [ROW_W-1:0]          p_row_reg, p_row_next;
    logic [PROCESSES-1:0]      done_reg, done_next;
    logic [NM_W-1:0]           nomove_reg, nomove_next;
    logic [IDX_W-1:0]          scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]          eval_idx_reg, eval_idx_next;
    logic                      eval_valid_reg, eval_valid_next;
    logic                      safe_reg, safe_next;

    logic                         rsp_valid_reg;
    logic                         granted_reg;
    logic [bsa_pkg::STATUS_W-1:0] status_reg;
    logic                         emit, res_granted, out_free;
    logic [bsa_pkg::STATUS_W-1:0] res_status;

    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic [ROW_W-1:0] mem_wdata, rd_row;

    logic [CB-1:0] row_max  [RESOURCES];
    logic [CB-1:0] row_held [RESOURCES];
    logic [CB-1:0] free_u   [RESOURCES];
    logic [CB-1:0] hp       [RESOURCES];
    logic [ROW_W-1:0] row_set, row_rel, row_grant;
    logic over_need, over_avail, fits, take, is_p;
    logic [CB*4-1:0] raw_cnt;

    bsa_row_mem #(
        .DEPTH (PROCESSES),
        .ROW_W (ROW_W),
        .IDX_W (IDX_W)
    ) u_rows (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_row)
    );

    assign raw_cnt = {CB'(cmd.count_3), CB'(cmd.count_2), CB'(cmd.count_1),
                      CB'(cmd.count_0)};
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == bsa_pkg::ST_IDLE);
    assign is_p      = (eval_idx_reg == pidx_reg);

    always_comb
    begin
        over_need  = 1'b0;
        over_avail = 1'b0;
        fits       = 1'b1;
        for (int r = 0; r < RESOURCES; r++)
        begin
            cnt_in[r]   = raw_cnt[r*CB +: CB];
            row_max[r]  = rd_row[r*CB +: CB];
            row_held[r] = rd_row[(RESOURCES + r)*CB +: CB];
            free_u[r]   = (total_reg[r] >= in_use_reg[r]) ?
                          total_reg[r] - in_use_reg[r] : '0;
            if (req_reg[r] > row_max[r] - row_held[r])
            begin
                over_need = 1'b1;
            end
            if (req_reg[r] > free_u[r])
            begin
                over_avail = 1'b1;
            end
            hp[r] = row_held[r] + (is_p ? req_reg[r] : '0);
            if (WK_W'(row_max[r] - hp[r]) > work_reg[r])
            begin
                fits = 1'b0;
            end
            row_set[r*CB +: CB]                 = req_reg[r];
            row_set[(RESOURCES + r)*CB +: CB]   = '0;
            row_rel[r*CB +: CB]                 = row_max[r];
            row_rel[(RESOURCES + r)*CB +: CB]   = '0;
            row_grant[r*CB +: CB]               = p_row_reg[r*CB +: CB];
            row_grant[(RESOURCES + r)*CB +: CB] =
                p_row_reg[(RESOURCES + r)*CB +: CB] + req_reg[r];
        end
        take = !done_reg[eval_idx_reg] && fits;
    end

    always_comb
    begin
        state_next      = state_reg;
        mem_we          = 1'b0;
        mem_waddr       = pidx_reg;
        mem_wdata       = row_grant;
        mem_re          = 1'b0;
        mem_raddr       = scan_addr_reg;
        emit            = 1'b0;
        res_granted     = 1'b0;
        res_status      = bsa_pkg::STAT_OK;
        in_use_next     = in_use_reg;
        work_next       = work_reg;
        done_next       = done_reg;
        nomove_next     = nomove_reg;
        scan_addr_next  = scan_addr_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = scan_addr_reg;
        safe_next       = safe_reg;
        p_row_next      = p_row_reg;
        case (state_reg)
            bsa_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = IDX_W'(cmd.process_index);
                    state_next = bsa_pkg::ST_CHK;
                end
            end
            bsa_pkg::ST_CHK:
            begin
                p_row_next = rd_row;
                if (!in_range_reg || op_reg == bsa_pkg::OP_NONE)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = bsa_pkg::ST_IDLE;
                    end
                end
                else if (op_reg == bsa_pkg::OP_SET_MAX || op_reg == bsa_pkg::OP_RELEASE)
                begin
                    if (out_free)
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = (op_reg == bsa_pkg::OP_SET_MAX) ? row_set : row_rel;
                        emit        = 1'b1;
                        res_granted = 1'b1;
                        for (int r = 0; r < RESOURCES; r++)
                        begin
                            in_use_next[r] = (in_use_reg[r] >= row_held[r]) ?
                                             in_use_reg[r] - row_held[r] : '0;
                        end
                        state_next = bsa_pkg::ST_IDLE;
                    end
                end
                else if (over_need || over_avail)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        res_status = over_need ? bsa_pkg::STAT_NEED : bsa_pkg::STAT_AVAIL;
                        state_next = bsa_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        work_next[r] = WK_W'(free_u[r] - req_reg[r]);
                    end
                    done_next      = '0;
                    nomove_next    = '0;
                    scan_addr_next = '0;
                    state_next     = bsa_pkg::ST_SCAN;
                end
            end
            bsa_pkg::ST_SCAN:
            begin
                // rows stream out one per cycle; each is evaluated from the registered read data
                mem_re          = 1'b1;
                mem_raddr       = scan_addr_reg;
                scan_addr_next  = (32'(scan_addr_reg) == 32'(PROCESSES - 1)) ?
                                  '0 : scan_addr_reg + 1'b1;
                eval_valid_next = 1'b1;
                eval_idx_next   = scan_addr_reg;
                if (eval_valid_reg)
                begin
                    if (take)
                    begin
                        done_next[eval_idx_reg] = 1'b1;
                        nomove_next = '0;
                        for (int r = 0; r < RESOURCES; r++)
                        begin
                            work_next[r] = work_reg[r] + WK_W'(hp[r]);
                        end
                    end
                    else
                    begin
                        nomove_next = nomove_reg + 1'b1;
                    end
                    // a full lap with no progress means the rest can never finish
                    if (&done_next)
                    begin
                        safe_next       = 1'b1;
                        eval_valid_next = 1'b0;
                        state_next      = bsa_pkg::ST_FIN;
                    end
                    else if (nomove_next == NM_W'(PROCESSES))
                    begin
                        safe_next       = 1'b0;
                        eval_valid_next = 1'b0;
                        state_next      = bsa_pkg::ST_FIN;
                    end
                end
            end
            bsa_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = bsa_pkg::ST_IDLE;
                    if (safe_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = row_grant;
                        res_granted = 1'b1;
                        for (int r = 0; r < RESOURCES; r++)
                        begin
                            in_use_next[r] = in_use_reg[r] + req_reg[r];
                        end
                    end
                    else
                    begin
                        res_status = bsa_pkg::STAT_UNSAFE;
                    end
                end
            end
            default:
            begin
                state_next = bsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bsa_pkg::ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            eval_valid_reg <= 1'b0;
            done_reg       <= '0;
            nomove_reg     <= '0;
            scan_addr_reg  <= '0;
            safe_reg       <= 1'b0;
            for (int r = 0; r < RESOURCES; r++)
            begin
                total_reg[r]  <= '0;
                in_use_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
            done_reg       <= done_next;
            nomove_reg     <= nomove_next;
            scan_addr_reg  <= scan_addr_next;
            safe_reg       <= safe_next;
            in_use_reg     <= in_use_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                for (int r = 0; r < RESOURCES; r++)
                begin
                    if (cfg_index == bsa_pkg::CFG_IDX_W'(r))
                    begin
                        total_reg[r] <= CB'(cfg_data);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        eval_idx_reg <= eval_idx_next;
        p_row_reg    <= p_row_next;
        if (emit)
        begin
            granted_reg <= res_granted;
            status_reg  <= res_status;
        end
        if (cmd.valid && cmd.ready)
        begin
            op_reg       <= cmd.opcode;
            pidx_reg     <= IDX_W'(cmd.process_index);
            in_range_reg <= (32'(cmd.process_index) < 32'(PROCESSES));
            req_reg      <= cnt_in;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.granted = granted_reg;
    assign rsp.status  = status_reg;

`ifndef SYNTHESIS
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == bsa_pkg::ST_CHK ||
                                  $past(state_reg) == bsa_pkg::ST_FIN))
        else $error("response raised outside check or finish");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && granted_reg) |-> (status_reg == bsa_pkg::STAT_OK))
        else $error("grant with failure status");

    a_done_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bsa_pkg::ST_SCAN && $past(state_reg) == bsa_pkg::ST_SCAN)
        |-> ((done_reg & $past(done_reg)) == $past(done_reg)))
        else $error("finished flag dropped during scan");

    a_nomove_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nomove_reg <= NM_W'(PROCESSES))
        else $error("no-progress counter overran");

    a_accept_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == bsa_pkg::ST_CHK))
        else $error("accepted transaction not checked");
`endif

endmodule
